// ===== sv/mwo_pkg.sv =====
`default_nettype none

package mwo_pkg;

  localparam int PHASE_W  = 32;
  localparam int BURST_W  = 25;
  localparam int MODE_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int CFG_W    = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [MAG_W-1:0]   FULL_SCALE    = 15'd32767;
  localparam logic [PHASE_W-1:0] HALF_PHASE    = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] QUARTER_PHASE = 32'h4000_0000;
  localparam longint unsigned    HALF_PI_Q30   = 64'd1686629713;

  typedef enum logic [MODE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2
  } wave_mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PHASE_INC = 2'd0,
    REG_WAVE_MODE = 2'd1,
    REG_BURST_LEN = 2'd2
  } cfg_reg_t;

  // floor(32767*sin(pi/2*k/2^bits)) via q30 taylor series
  function automatic logic [MAG_W-1:0] quarter_sine(input int k, input int bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    x    = (HALF_PI_Q30 * longint'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 272;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 64'd32767) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/mwo_sine_rom.sv =====
`default_nettype none

module mwo_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_BITS-1:0]       rd_addr,
  output logic      [mwo_pkg::MAG_W-1:0]  rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  typedef logic [mwo_pkg::MAG_W-1:0] rom_array_t [DEPTH];

  function automatic rom_array_t build_rom();
    rom_array_t tbl;
    for (int k = 0; k < DEPTH; k++) begin
      tbl[k] = mwo_pkg::quarter_sine(k, ADDR_BITS);
    end
    return tbl;
  endfunction

  localparam rom_array_t ROM_DATA = build_rom();

  logic [mwo_pkg::MAG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM_DATA[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/multi_waveform_oscillator_unit.sv =====
// an accepted input is registered in the waveform stage (sine rom read), then in the output
// register, where out_tvalid rises; an output stall can hold the item in the waveform stage
// throughput: one sample per cycle, set by the phase accumulator and the registered sine rom
// if unstalled; a stalled result blocks input only once the waveform stage also holds an item
// reset: synchronous active-low, clears phase, sample counter, pipeline valids and registers
// (phase_increment 0, wave_mode sine, burst_length 1); sine rom contents are constant
`default_nettype none

module multi_waveform_oscillator_unit #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int COUNT_BITS      = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // [0] restart, [7:1] zero
  input  wire logic [7:0]                        in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [15:0] sample
  output logic [mwo_pkg::SAMPLE_W-1:0]           out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_wen,
  input  wire logic [mwo_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [mwo_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int STB   = SINE_TABLE_BITS;
  localparam int CMP_W = ((COUNT_BITS > mwo_pkg::BURST_W) ? COUNT_BITS : mwo_pkg::BURST_W) + 1;
  localparam logic [CMP_W-1:0] CNT_MAX = (CMP_W'(1) << COUNT_BITS) - CMP_W'(1);

  // configuration
  logic [mwo_pkg::PHASE_W-1:0] phase_inc_r;
  logic [mwo_pkg::MODE_W-1:0]  wave_mode_r;
  logic [mwo_pkg::BURST_W-1:0] burst_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      wave_mode_r <= mwo_pkg::WAVE_SINE;
      burst_len_r <= mwo_pkg::BURST_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        mwo_pkg::REG_PHASE_INC: phase_inc_r <= cfg_wdata;
        mwo_pkg::REG_WAVE_MODE: wave_mode_r <= cfg_wdata[mwo_pkg::MODE_W-1:0];
        mwo_pkg::REG_BURST_LEN: burst_len_r <= cfg_wdata[mwo_pkg::BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulator stage
  logic [mwo_pkg::PHASE_W-1:0] phase_r, phase_cur;
  logic [COUNT_BITS-1:0]       count_r, count_cur, count_nxt;
  logic                        in_xfer, restart;
  logic [mwo_pkg::BURST_W-1:0] len_m1;
  logic [CMP_W-1:0]            len_m1_w, end_idx;
  logic                        last_cur;
  logic [1:0]                  quad;
  logic [STB-1:0]              tbl_idx, rom_addr;

  assign in_xfer   = in_tvalid & in_tready;
  assign restart   = in_tdata[0];
  assign phase_cur = restart ? '0 : phase_r;
  assign count_cur = restart ? '0 : count_r;

  assign len_m1   = (burst_len_r == '0) ? '0 : burst_len_r - mwo_pkg::BURST_W'(1);
  assign len_m1_w = CMP_W'(len_m1);
  assign end_idx  = (len_m1_w > CNT_MAX) ? CNT_MAX : len_m1_w;
  assign last_cur = (CMP_W'(count_cur) == end_idx);
  assign count_nxt = last_cur ? '0 : count_cur + COUNT_BITS'(1);

  assign quad     = phase_cur[31:30];
  assign tbl_idx  = phase_cur[29 -: STB];
  // falling quadrants read the table mirrored
  assign rom_addr = quad[0] ? ({STB{1'b0}} - tbl_idx) : tbl_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      count_r <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_cur + phase_inc_r;
      count_r <= count_nxt;
    end
  end

  // waveform stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic [mwo_pkg::PHASE_W-1:0] s1_phase_r;
  logic                        s1_full_r;
  logic                        s1_last_r;
  logic                        s1_move;
  logic [mwo_pkg::MAG_W-1:0]   rom_q;

  mwo_sine_rom #(
    .ADDR_BITS (STB)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  logic out_valid_r, out_valid_nxt;
  logic [mwo_pkg::SAMPLE_W-1:0] out_sample_r;
  logic out_last_r;

  assign s1_move      = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready    = ~s1_valid_r | s1_move;
  assign s1_valid_nxt = in_xfer | (s1_valid_r & ~s1_move);
  assign out_valid_nxt = s1_move | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_phase_r <= phase_cur;
      s1_full_r  <= quad[0] & (tbl_idx == '0);
      s1_last_r  <= last_cur;
    end
  end

  logic [mwo_pkg::MAG_W-1:0]    sine_mag;
  logic [mwo_pkg::SAMPLE_W-1:0] sine_val, square_val, tri_val, sample_val;
  logic [mwo_pkg::PHASE_W-1:0]  tri_f;
  logic                         tri_rise;
  logic [30:0]                  tri_d;
  logic [45:0]                  tri_prod;
  logic [mwo_pkg::MAG_W-1:0]    tri_mag;

  always_comb begin
    sine_mag = s1_full_r ? mwo_pkg::FULL_SCALE : rom_q;
    sine_val = s1_phase_r[31] ? ({mwo_pkg::SAMPLE_W{1'b0}} - {1'b0, sine_mag})
                              : {1'b0, sine_mag};

    square_val = (s1_phase_r > mwo_pkg::HALF_PHASE)
               ? {1'b0, mwo_pkg::FULL_SCALE}
               : ({mwo_pkg::SAMPLE_W{1'b0}} - {1'b0, mwo_pkg::FULL_SCALE});

    tri_f    = (s1_phase_r > mwo_pkg::HALF_PHASE) ? ('0 - s1_phase_r) : s1_phase_r;
    tri_rise = (tri_f >= mwo_pkg::QUARTER_PHASE);
    tri_d    = tri_rise ? 31'(tri_f - mwo_pkg::QUARTER_PHASE)
                        : 31'(mwo_pkg::QUARTER_PHASE - tri_f);
    tri_prod = 46'(tri_d) * 46'(mwo_pkg::FULL_SCALE);
    tri_mag  = tri_prod[44:30];
    tri_val  = tri_rise ? {1'b0, tri_mag}
                        : ({mwo_pkg::SAMPLE_W{1'b0}} - {1'b0, tri_mag});

    unique case (wave_mode_r)
      mwo_pkg::WAVE_SINE:     sample_val = sine_val;
      mwo_pkg::WAVE_SQUARE:   sample_val = square_val;
      mwo_pkg::WAVE_TRIANGLE: sample_val = tri_val;
      default:                sample_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_sample_r <= sample_val;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |-> !in_xfer)
    else $error("waveform stage overwritten while holding");

  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tdata[0]) |=> (s1_phase_r == '0))
    else $error("restart did not clear phase");

  a_single_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && burst_len_r == mwo_pkg::BURST_W'(1) && count_cur == '0) |=> s1_last_r)
    else $error("burst of one not flagged as last");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sample_r != 16'h8000))
    else $error("sample out of range");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(s1_valid_r))
    else $error("result without a source item");

endmodule

`default_nettype wire

// ===== tb/multi_waveform_oscillator_unit_test.sv =====
`default_nettype none

typedef struct packed {
  logic [15:0] sample;
  logic        burst_end;
} osc_result_t;

class osc_scoreboard;
  localparam int ROM_BITS = 10;
  localparam int ROM_SIZE = 1 << ROM_BITS;

  logic [14:0]  quarter_rom[ROM_SIZE];
  logic [31:0]  phase_acc;
  logic [23:0]  sample_count;
  logic [31:0]  phase_step;
  logic [1:0]   wave_sel;
  logic [24:0]  burst_len;
  osc_result_t  expected_samples[$];
  int           errors;

  function new();
    longint unsigned x, x2, term, v;
    longint          acc;
    for (int k = 0; k < ROM_SIZE; k++) begin
      x    = (mwo_pkg::HALF_PI_Q30 * k) >> ROM_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (acc * 32767) >> 30;
      if (v > 32767) begin
        v = 32767;
      end
      quarter_rom[k] = v[14:0];
    end
    phase_acc    = '0;
    sample_count = '0;
    phase_step   = '0;
    wave_sel     = mwo_pkg::WAVE_SINE;
    burst_len    = 25'd1;
    errors       = 0;
  endfunction

  function void apply_write(logic [1:0] addr, logic [31:0] data);
    case (addr)
      mwo_pkg::REG_PHASE_INC: phase_step = data;
      mwo_pkg::REG_WAVE_MODE: wave_sel = data[1:0];
      mwo_pkg::REG_BURST_LEN: burst_len = data[24:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] sine_of(logic [31:0] p);
    logic [9:0]  idx;
    logic [15:0] mag;
    idx = p[29:20];
    if (p[30]) begin
      mag = (idx == 0) ? 16'd32767 : {1'b0, quarter_rom[ROM_SIZE - idx]};
    end else begin
      mag = {1'b0, quarter_rom[idx]};
    end
    return p[31] ? 16'd0 - mag : mag;
  endfunction

  function logic [15:0] triangle_of(logic [31:0] p);
    longint unsigned f, mag;
    f = (p > mwo_pkg::HALF_PHASE) ? (64'h1_0000_0000 - p) : p;
    if (f >= mwo_pkg::QUARTER_PHASE) begin
      mag = ((f - mwo_pkg::QUARTER_PHASE) * 32767) >> 30;
      return mag[15:0];
    end
    mag = ((mwo_pkg::QUARTER_PHASE - f) * 32767) >> 30;
    return 16'd0 - mag[15:0];
  endfunction

  function void note_request(bit restart);
    logic [24:0] len;
    osc_result_t r;
    if (restart) begin
      phase_acc    = '0;
      sample_count = '0;
    end
    len = burst_len;
    if (len == 0) begin
      len = 25'd1;
    end
    if (len > 25'h100_0000) begin
      len = 25'h100_0000;
    end
    case (wave_sel)
      mwo_pkg::WAVE_SINE:     r.sample = sine_of(phase_acc);
      mwo_pkg::WAVE_SQUARE:   r.sample = (phase_acc > mwo_pkg::HALF_PHASE) ? 16'sd32767
                                                                           : -16'sd32767;
      mwo_pkg::WAVE_TRIANGLE: r.sample = triangle_of(phase_acc);
      default:                r.sample = '0;
    endcase
    r.burst_end = ({1'b0, sample_count} == len - 25'd1);
    expected_samples.push_back(r);
    sample_count = r.burst_end ? '0 : sample_count + 24'd1;
    phase_acc    = phase_acc + phase_step;
  endfunction

  function void check_sample(logic [15:0] sample, logic burst_end);
    osc_result_t e;
    if (expected_samples.size() == 0) begin
      $error("unexpected sample transfer: sample %0d burst_end %0d", $signed(sample), burst_end);
      errors++;
      return;
    end
    e = expected_samples.pop_front();
    if (sample !== e.sample) begin
      $error("sample mismatch: expected %0d, actual %0d", $signed(e.sample), $signed(sample));
      errors++;
    end
    if (burst_end !== e.burst_end) begin
      $error("burst_end mismatch: expected %0d, actual %0d", e.burst_end, burst_end);
      errors++;
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module multi_waveform_oscillator_unit_test;

  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0] WAVE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic                           clk;
  logic                           rst_n;
  logic [7:0]                     in_tdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [mwo_pkg::SAMPLE_W-1:0]   out_tdata;
  logic                           out_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_wen;
  logic [mwo_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [mwo_pkg::CFG_W-1:0]      cfg_wdata;

  osc_scoreboard sb = new();
  int            tx_idle_pct;
  int            rx_idle_pct;
  int            cycle_count;

  multi_waveform_oscillator_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_sample(out_tdata, out_tlast);
    end
  end

  task automatic send_tick(input bit restart);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!in_tready);
    sb.note_request(restart);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_osc(input logic [31:0] inc, input logic [1:0] mode,
                             input logic [24:0] len, input bit stray_write);
    logic [1:0]  addr[4];
    logic [31:0] data[4];
    int          n;
    wait_drained();
    addr = '{mwo_pkg::REG_PHASE_INC, mwo_pkg::REG_WAVE_MODE, mwo_pkg::REG_BURST_LEN,
             REG_UNUSED};
    data = '{inc, {30'b0, mode}, {7'b0, len}, $urandom()};
    n = stray_write ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_wen   <= 1'b1;
      cfg_addr  <= addr[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      sb.apply_write(addr[i], data[i]);
    end
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [31:0] inc;
    logic [24:0] len;
    cycle_count = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 53;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_wen    <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: phase stays at zero, every sample ends a burst
    send_tick(1'b0);
    send_tick(1'b1);

    // sine at the quarter points
    program_osc(32'h4000_0000, mwo_pkg::WAVE_SINE, 25'd4, 1'b0);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);

    // square both levels and exactly one half, zero burst length, stray register index
    program_osc(32'hC000_0000, mwo_pkg::WAVE_SQUARE, 25'd0, 1'b1);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);

    // triangle across the fold, burst longer than the counter
    program_osc(32'h2000_0000, mwo_pkg::WAVE_TRIANGLE, 25'h1FF_FFFF, 1'b0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);

    // unused mode
    program_osc(32'hFFFF_FFFF, WAVE_UNUSED, 25'd3, 1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);

    // burst shrinks below the running count
    inc = $urandom();
    program_osc(inc, mwo_pkg::WAVE_SINE, 25'd10, 1'b0);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    program_osc(inc, mwo_pkg::WAVE_SINE, 25'd2, 1'b0);
    repeat (2) send_tick(1'b0);

    for (int g = 0; g < 3; g++) begin
      tx_idle_pct = (g == 0) ? 24 : (g == 1) ? 53 : 0;
      rx_idle_pct = (g == 0) ? 53 : (g == 1) ? 24 : 0;
      for (int s = 0; s < 8; s++) begin
        inc = $urandom();
        len = 25'($urandom_range(1, 40));
        case (s)
          1: inc = '0;
          2: inc = '1;
          3: len = '0;
          4: len = '1;
          5: inc = $urandom_range(1, 4096);
          6: len = 25'h100_0000;
          default: ;
        endcase
        program_osc(inc, 2'($urandom_range(0, 3)), len, s == 7);
        for (int i = 0; i < 50; i++) begin
          if (g == 0 && s == 2 && i == 25) begin
            wait_drained();
          end
          send_tick(i == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
